>>> design/arfs_pkg.sv
// Package for the aligned read filter and statistics block.
// Holds field widths, flag positions, counter indexes, class codes and the update struct.
// Depends on nothing.
`default_nettype none

package arfs_pkg;

  localparam int unsigned NumCounters = 14;
  localparam int unsigned SelWidth    = 4;
  localparam int unsigned FlagWidth   = 16;
  localparam int unsigned RefIdWidth  = 32;
  localparam int unsigned MapqWidth   = 8;
  localparam int unsigned ThrWidth    = 9;
  localparam int unsigned ValueWidth  = 48;
  localparam int unsigned ClassWidth  = 2;
  localparam int unsigned CfgWidth    = 32;

  localparam logic [ThrWidth-1:0]   ThrReset  = 9'd10;
  localparam logic [RefIdWidth-1:0] MitoReset = 32'hFFFF_FFFE;

  localparam logic CfgIdxThreshold = 1'b0;
  localparam logic CfgIdxMitoId    = 1'b1;

  localparam logic ReqClassify = 1'b0;
  localparam logic ReqReadback = 1'b1;

  localparam int unsigned FlPaired  = 0;
  localparam int unsigned FlProper  = 1;
  localparam int unsigned FlUnmap   = 2;
  localparam int unsigned FlMunmap  = 3;
  localparam int unsigned FlReverse = 4;
  localparam int unsigned FlRead1   = 6;
  localparam int unsigned FlRead2   = 7;
  localparam int unsigned FlSecond  = 8;
  localparam int unsigned FlQcfail  = 9;
  localparam int unsigned FlSuppl   = 11;

  localparam int unsigned CReads   = 0;
  localparam int unsigned CMapped  = 1;
  localparam int unsigned CPairmap = 2;
  localparam int unsigned CPairall = 3;
  localparam int unsigned CProper  = 4;
  localparam int unsigned CSgltn   = 5;
  localparam int unsigned CRead1   = 6;
  localparam int unsigned CRead2   = 7;
  localparam int unsigned CDiffchr = 8;
  localparam int unsigned CPstrand = 9;
  localparam int unsigned CMstrand = 10;
  localparam int unsigned CQual    = 11;
  localparam int unsigned CMito    = 12;
  localparam int unsigned CUsable  = 13;

  localparam logic [ClassWidth-1:0] ClsUsable = 2'd0;
  localparam logic [ClassWidth-1:0] ClsMito   = 2'd1;
  localparam logic [ClassWidth-1:0] ClsFilt   = 2'd2;

  typedef struct packed {
    logic [NumCounters-1:0] inc;
    logic [ClassWidth-1:0]  cls;
  } arfs_upd_t;

endpackage

`default_nettype wire

>>> design/arfs_req_if.sv
// Request channel of the aligned read filter: valid, ready and one read record.
// Depends on arfs_pkg.
`default_nettype none

interface arfs_req_if
  import arfs_pkg::*;
();
  logic                         valid;
  logic                         ready;
  logic                         req_type;
  logic [FlagWidth-1:0]         sam_flags;
  logic signed [RefIdWidth-1:0] reference_id;
  logic signed [RefIdWidth-1:0] mate_reference_id;
  logic [MapqWidth-1:0]         mapping_quality;
  logic [SelWidth-1:0]          counter_select;

  modport source (
    output valid, req_type, sam_flags, reference_id, mate_reference_id,
           mapping_quality, counter_select,
    input  ready
  );
  modport sink (
    input  valid, req_type, sam_flags, reference_id, mate_reference_id,
           mapping_quality, counter_select,
    output ready
  );
endinterface

`default_nettype wire

>>> design/arfs_res_if.sv
// Result channel of the aligned read filter: valid, ready, read class and counter value.
// Depends on arfs_pkg.
`default_nettype none

interface arfs_res_if
  import arfs_pkg::*;
();
  logic                  valid;
  logic                  ready;
  logic [ClassWidth-1:0] read_class;
  logic [ValueWidth-1:0] counter_value;

  modport source (output valid, read_class, counter_value, input ready);
  modport sink (input valid, read_class, counter_value, output ready);
endinterface

`default_nettype wire

>>> design/arfs_classify.sv
// Read classifier: decodes flags, reference ids and mapping quality into a class
// and the set of counters to increment. Depends on arfs_pkg.
`default_nettype none

module arfs_classify
  import arfs_pkg::*;
(
  input  wire logic                  req_type_i,
  input  wire logic [FlagWidth-1:0]  sam_flags_i,
  input  wire logic [RefIdWidth-1:0] reference_id_i,
  input  wire logic [RefIdWidth-1:0] mate_reference_id_i,
  input  wire logic [MapqWidth-1:0]  mapping_quality_i,
  input  wire logic [ThrWidth-1:0]   quality_threshold_i,
  input  wire logic [RefIdWidth-1:0] mito_reference_id_i,
  output arfs_upd_t                  upd_o
);

  logic filt;
  logic mito;
  logic qual;
  logic paired;

  always_comb begin
    filt   = sam_flags_i[FlQcfail] | sam_flags_i[FlSecond] |
             sam_flags_i[FlSuppl] | sam_flags_i[FlUnmap];
    mito   = (reference_id_i == mito_reference_id_i);
    qual   = ({1'b0, mapping_quality_i} >= quality_threshold_i);
    paired = sam_flags_i[FlPaired];

    upd_o.inc = '0;
    upd_o.cls = ClsUsable;

    if (req_type_i == ReqClassify) begin
      upd_o.inc[CReads] = 1'b1;
      if (filt) begin
        upd_o.cls = ClsFilt;
      end else begin
        upd_o.inc[CMito]    = mito;
        upd_o.inc[CMapped]  = 1'b1;
        upd_o.inc[CMstrand] = sam_flags_i[FlReverse];
        upd_o.inc[CPstrand] = ~sam_flags_i[FlReverse];
        upd_o.inc[CQual]    = qual;
        upd_o.inc[CPairall] = paired;
        upd_o.inc[CProper]  = paired & sam_flags_i[FlProper];
        upd_o.inc[CRead1]   = paired & sam_flags_i[FlRead1];
        upd_o.inc[CRead2]   = paired & ~sam_flags_i[FlRead1] & sam_flags_i[FlRead2];
        upd_o.inc[CSgltn]   = paired & sam_flags_i[FlMunmap];
        upd_o.inc[CPairmap] = paired & ~sam_flags_i[FlMunmap];
        upd_o.inc[CDiffchr] = paired & ~sam_flags_i[FlMunmap] &
                              (mate_reference_id_i != reference_id_i);
        if (!qual) begin
          upd_o.cls = ClsFilt;
        end else if (mito) begin
          upd_o.cls = ClsMito;
        end
      end
      upd_o.inc[CUsable] = (upd_o.cls == ClsUsable);
    end
  end

endmodule

`default_nettype wire

>>> design/arfs_counters.sv
// Bank of fourteen wrapping statistics counters with one selectable read port.
// Depends on arfs_pkg.
`default_nettype none

module arfs_counters
  import arfs_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 48
) (
  input  wire logic                   clk_i,
  input  wire logic                   rst_ni,
  input  wire logic [NumCounters-1:0] inc_i,
  input  wire logic [SelWidth-1:0]    sel_i,
  output logic      [ValueWidth-1:0]  value_o
);

  logic [COUNTER_WIDTH-1:0] cnt_q [NumCounters];
  logic [63:0]              rd_wide;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < NumCounters; i++) begin
        cnt_q[i] <= '0;
      end
    end else begin
      for (int i = 0; i < NumCounters; i++) begin
        if (inc_i[i]) begin
          cnt_q[i] <= cnt_q[i] + COUNTER_WIDTH'(1);
        end
      end
    end
  end

  always_comb begin
    rd_wide = '0;
    if (sel_i < SelWidth'(NumCounters)) begin
      rd_wide = 64'(cnt_q[sel_i]);
    end
    value_o = rd_wide[ValueWidth-1:0];
  end

endmodule

`default_nettype wire

>>> design/aligned_read_filter_stats.sv
// Top level of the aligned read filter and statistics block.
// Depends on arfs_pkg, arfs_req_if, arfs_res_if, arfs_classify and arfs_counters.
//
// Requests arrive on req_i. A classify request carries the SAM flags, reference
// id, mate reference id and mapping quality of one read; the block returns its
// class (usable, mitochondrial or filtered) and bumps the statistics counters.
// A readback request returns the counter chosen by counter_select; selects 14
// and 15 return zero. Every request gives exactly one result on res_o.
// The configuration port writes the quality threshold (index 0) and the
// mitochondrial reference id (index 1). The user must write them only while
// the block is idle; the block itself does not enforce this. The result is
// registered: it enters the output register at the edge that takes the request.
// Throughput is one request per cycle unless the receiver stalls. The counters
// update at the accepting edge, so a readback sees every earlier classify request.
// When the receiver stalls the output register holds its result and req_i
// stays ready only while that register is free or being emptied.
// Reset clears all counters, sets the threshold to 10 and the mitochondrial id
// to -2, and empties the output register.
`default_nettype none

module aligned_read_filter_stats
  import arfs_pkg::*;
#(
  parameter int unsigned COUNTER_WIDTH = 48
) (
  input  wire logic                clk_i,
  input  wire logic                rst_ni,
  arfs_req_if.sink                 req_i,
  arfs_res_if.source               res_o,
  input  wire logic                cfg_we_i,
  input  wire logic                cfg_index_i,
  input  wire logic [CfgWidth-1:0] cfg_wdata_i
);

  logic [ThrWidth-1:0]   thr_q;
  logic [RefIdWidth-1:0] mito_q;
  logic                  valid_q;
  logic [ClassWidth-1:0] class_q, class_d;
  logic [ValueWidth-1:0] value_q, value_d;
  logic                  accept;
  arfs_upd_t             upd;
  logic [ValueWidth-1:0] rd_value;

  assign req_i.ready = ~valid_q | res_o.ready;
  assign accept      = req_i.valid & req_i.ready;

  arfs_classify u_classify (
    .req_type_i          (req_i.req_type),
    .sam_flags_i         (req_i.sam_flags),
    .reference_id_i      (req_i.reference_id),
    .mate_reference_id_i (req_i.mate_reference_id),
    .mapping_quality_i   (req_i.mapping_quality),
    .quality_threshold_i (thr_q),
    .mito_reference_id_i (mito_q),
    .upd_o               (upd)
  );

  arfs_counters #(
    .COUNTER_WIDTH (COUNTER_WIDTH)
  ) u_counters (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .inc_i   (upd.inc & {NumCounters{accept}}),
    .sel_i   (req_i.counter_select),
    .value_o (rd_value)
  );

  always_comb begin
    class_d = upd.cls;
    value_d = (req_i.req_type == ReqReadback) ? rd_value : '0;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q  <= ThrReset;
      mito_q <= MitoReset;
    end else if (cfg_we_i) begin
      case (cfg_index_i)
        CfgIdxThreshold: thr_q  <= cfg_wdata_i[ThrWidth-1:0];
        CfgIdxMitoId:    mito_q <= cfg_wdata_i[RefIdWidth-1:0];
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (req_i.ready) begin
      valid_q <= req_i.valid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      class_q <= class_d;
      value_q <= value_d;
    end
  end

  assign res_o.valid         = valid_q;
  assign res_o.read_class    = class_q;
  assign res_o.counter_value = value_q;

endmodule

`default_nettype wire

>>> tb/sv/arfs_stats_checker.sv
// Checker for the aligned read filter: watches the request, result and register channels.
// Keeps its own copy of the statistics counters and settings, and compares every result.
// Depends on arfs_pkg, arfs_req_if and arfs_res_if.
module arfs_stats_checker
  import arfs_pkg::*;
(
  input  logic                clk_i,
  input  logic                rst_ni,
  arfs_req_if                 req_mon,
  arfs_res_if                 res_mon,
  input  logic                cfg_we_i,
  input  logic                cfg_index_i,
  input  logic [CfgWidth-1:0] cfg_wdata_i,
  output int                  fail_count_o,
  output int                  pending_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [ClassWidth-1:0] cls;
    logic [ValueWidth-1:0] value;
  } outcome_t;

  logic [ValueWidth-1:0] tally [NumCounters];
  logic [ThrWidth-1:0]   min_mapq;
  logic [RefIdWidth-1:0] mito_id;
  outcome_t              outcome_q [$];
  int                    fails;

  task automatic report(input string what);
    fails++;
    $display("[%0t] mismatch: %s", $time, what);
  endtask

  function automatic void bump(input int unsigned idx);
    tally[idx] = tally[idx] + 1'b1;
  endfunction

  function automatic outcome_t tally_request(input logic rtype,
      input logic [FlagWidth-1:0] fl, input logic [RefIdWidth-1:0] tid,
      input logic [RefIdWidth-1:0] mtid, input logic [MapqWidth-1:0] mapq,
      input logic [SelWidth-1:0] sel);
    outcome_t o;
    o.cls   = ClsUsable;
    o.value = '0;
    if (rtype == ReqReadback) begin
      if (sel < NumCounters) begin
        o.value = tally[sel];
      end
      return o;
    end
    bump(CReads);
    if (fl[FlQcfail] || fl[FlSecond] || fl[FlSuppl] || fl[FlUnmap]) begin
      o.cls = ClsFilt;
    end else begin
      if (tid == mito_id) begin
        bump(CMito);
        o.cls = ClsMito;
      end
      bump(CMapped);
      if (fl[FlReverse]) begin
        bump(CMstrand);
      end else begin
        bump(CPstrand);
      end
      if ({1'b0, mapq} >= min_mapq) begin
        bump(CQual);
      end else begin
        o.cls = ClsFilt;
      end
      if (fl[FlPaired]) begin
        bump(CPairall);
        if (fl[FlProper]) bump(CProper);
        if (fl[FlRead1]) begin
          bump(CRead1);
        end else if (fl[FlRead2]) begin
          bump(CRead2);
        end
        if (fl[FlMunmap]) begin
          bump(CSgltn);
        end else begin
          bump(CPairmap);
          if (mtid != tid) bump(CDiffchr);
        end
      end
    end
    if (o.cls == ClsUsable) bump(CUsable);
    return o;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    outcome_t want;
    if (!rst_ni) begin
      for (int i = 0; i < NumCounters; i++) tally[i] = '0;
      min_mapq = ThrReset;
      mito_id  = MitoReset;
      outcome_q.delete();
      fails    = 0;
    end else begin
      if (cfg_we_i) begin
        if (cfg_index_i == CfgIdxThreshold) begin
          min_mapq = cfg_wdata_i[ThrWidth-1:0];
        end else begin
          mito_id = cfg_wdata_i;
        end
      end
      if (res_mon.valid && res_mon.ready) begin
        if (outcome_q.size() == 0) begin
          report("result with no request outstanding");
        end else begin
          want = outcome_q.pop_front();
          if (res_mon.read_class !== want.cls) begin
            report($sformatf("read_class %0d, predicted %0d", res_mon.read_class, want.cls));
          end
          if (res_mon.counter_value !== want.value) begin
            report($sformatf("counter_value %0d, predicted %0d",
                             res_mon.counter_value, want.value));
          end
        end
      end
      if (req_mon.valid && req_mon.ready) begin
        outcome_q.push_back(tally_request(req_mon.req_type, req_mon.sam_flags,
                                          req_mon.reference_id, req_mon.mate_reference_id,
                                          req_mon.mapping_quality, req_mon.counter_select));
      end
    end
    fail_count_o = fails;
    pending_o    = outcome_q.size();
  end

endmodule

>>> tb/sv/tb_aligned_read_filter_stats.sv
// Top of the aligned read filter testbench: clock, reset, request stimulus, receiver stalls.
// Register settings change between phases; the checker judges results, this module the run.
// Depends on arfs_pkg, arfs_req_if, arfs_res_if, arfs_stats_checker and the block itself.
module tb_aligned_read_filter_stats
  import arfs_pkg::*;
;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [FlagWidth-1:0] FPaired  = FlagWidth'(1 << FlPaired);
  localparam logic [FlagWidth-1:0] FProper  = FlagWidth'(1 << FlProper);
  localparam logic [FlagWidth-1:0] FUnmap   = FlagWidth'(1 << FlUnmap);
  localparam logic [FlagWidth-1:0] FMunmap  = FlagWidth'(1 << FlMunmap);
  localparam logic [FlagWidth-1:0] FReverse = FlagWidth'(1 << FlReverse);
  localparam logic [FlagWidth-1:0] FRead1   = FlagWidth'(1 << FlRead1);
  localparam logic [FlagWidth-1:0] FRead2   = FlagWidth'(1 << FlRead2);
  localparam logic [FlagWidth-1:0] FSecond  = FlagWidth'(1 << FlSecond);
  localparam logic [FlagWidth-1:0] FQcfail  = FlagWidth'(1 << FlQcfail);
  localparam logic [FlagWidth-1:0] FSuppl   = FlagWidth'(1 << FlSuppl);

  localparam logic [RefIdWidth-1:0] RefMax  = 32'h7FFF_FFFF;
  localparam logic [RefIdWidth-1:0] RefNone = 32'hFFFF_FFFF;

  localparam int NumPhases     = 8;
  localparam int ItemsPerPhase = 240;
  localparam int HoldAt        = 620;
  localparam int HoldCycles    = 400;
  localparam int QuietLimit    = 2000;

  typedef enum logic [1:0] {RdyAlways, RdyCoin, RdyMostly, RdySparse} rdy_mode_e;

  logic                clk_i = 1'b0;
  logic                rst_ni;
  logic                cfg_we;
  logic                cfg_index;
  logic [CfgWidth-1:0] cfg_wdata;
  int                  fail_count;
  int                  pending;
  int                  sent_count = 0;
  int                  burst_left = 0;
  int                  quiet_cycles = 0;

  arfs_req_if req_if ();
  arfs_res_if res_if ();

  aligned_read_filter_stats u_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .req_i       (req_if),
    .res_o       (res_if),
    .cfg_we_i    (cfg_we),
    .cfg_index_i (cfg_index),
    .cfg_wdata_i (cfg_wdata)
  );

  arfs_stats_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .req_mon      (req_if),
    .res_mon      (res_if),
    .cfg_we_i     (cfg_we),
    .cfg_index_i  (cfg_index),
    .cfg_wdata_i  (cfg_wdata),
    .fail_count_o (fail_count),
    .pending_o    (pending)
  );

  always #5ns clk_i = ~clk_i;

  always @(posedge clk_i) begin
    if (!rst_ni || (req_if.valid && req_if.ready) || (res_if.valid && res_if.ready)) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= QuietLimit) begin
      $display("FAIL");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // The receiver switches among random stall patterns, and once
  // holds off for a long stretch so that the block backs up onto its input.
  initial begin
    rdy_mode_e mode;
    int        run;
    bit        held;
    mode = RdyAlways;
    run  = 0;
    held = 1'b0;
    res_if.ready <= 1'b0;
    @(posedge rst_ni);
    forever begin
      @(negedge clk_i);
      if (!held && sent_count >= HoldAt) begin
        held = 1'b1;
        res_if.ready <= 1'b0;
        repeat (HoldCycles) @(negedge clk_i);
      end
      if (run == 0) begin
        mode = rdy_mode_e'($urandom_range(0, 3));
        run  = $urandom_range(8, 80);
      end
      run--;
      case (mode)
        RdyAlways: res_if.ready <= 1'b1;
        RdyCoin:   res_if.ready <= 1'($urandom_range(0, 1));
        RdyMostly: res_if.ready <= ($urandom_range(0, 9) != 0);
        default:   res_if.ready <= (run % 4 == 0);
      endcase
    end
  end

  task automatic send_req(input logic rt, input logic [FlagWidth-1:0] fl,
      input logic [RefIdWidth-1:0] tid, input logic [RefIdWidth-1:0] mtid,
      input logic [MapqWidth-1:0] mapq, input logic [SelWidth-1:0] sel);
    req_if.valid             <= 1'b1;
    req_if.req_type          <= rt;
    req_if.sam_flags         <= fl;
    req_if.reference_id      <= tid;
    req_if.mate_reference_id <= mtid;
    req_if.mapping_quality   <= mapq;
    req_if.counter_select    <= sel;
    do @(posedge clk_i); while (!req_if.ready);
    @(negedge clk_i);
    sent_count++;
    if (burst_left > 0) begin
      burst_left--;
    end else begin
      req_if.valid <= 1'b0;
      repeat ($urandom_range(1, 12)) @(negedge clk_i);
      burst_left = ($urandom_range(0, 4) == 0) ? $urandom_range(50, 200)
                                               : $urandom_range(0, 15);
    end
  endtask

  task automatic settle();
    req_if.valid <= 1'b0;
    while (pending != 0) @(negedge clk_i);
    repeat (2) @(negedge clk_i);
  endtask

  task automatic write_reg(input logic idx, input logic [CfgWidth-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_wdata <= data;
    @(negedge clk_i);
    cfg_we <= 1'b0;
    @(negedge clk_i);
  endtask

  initial begin
    logic                  rt;
    logic [FlagWidth-1:0]  fl;
    logic [RefIdWidth-1:0] tid;
    logic [RefIdWidth-1:0] mtid;
    logic [MapqWidth-1:0]  mapq;
    logic [ThrWidth-1:0]   thr;
    logic [RefIdWidth-1:0] mito;
    int                    lo;
    int                    hi;
    rst_ni                   <= 1'b0;
    req_if.valid             <= 1'b0;
    req_if.req_type          <= ReqClassify;
    req_if.sam_flags         <= '0;
    req_if.reference_id      <= '0;
    req_if.mate_reference_id <= '0;
    req_if.mapping_quality   <= '0;
    req_if.counter_select    <= '0;
    cfg_we                   <= 1'b0;
    cfg_index                <= CfgIdxThreshold;
    cfg_wdata                <= '0;
    repeat (11) @(negedge clk_i);
    rst_ni <= 1'b1;
    @(negedge clk_i);

    send_req(ReqReadback, '0, '0, '0, '0, SelWidth'(CReads));
    send_req(ReqReadback, '0, '0, '0, '0, 4'd14);
    send_req(ReqReadback, '1, '1, '1, '1, 4'd15);
    send_req(ReqClassify, '0, '0, '0, 8'd255, '0);
    send_req(ReqClassify, FUnmap, '0, '0, 8'd255, '0);
    send_req(ReqClassify, FSecond, '0, '0, 8'd255, '0);
    send_req(ReqClassify, FQcfail, '0, '0, 8'd255, '0);
    send_req(ReqClassify, FSuppl, '0, '0, 8'd255, '0);
    send_req(ReqClassify, '1, '0, '0, 8'd255, '0);
    send_req(ReqClassify, FPaired | FProper | FRead1 | FRead2, 32'd1, 32'd2, 8'd10, '0);
    send_req(ReqClassify, FPaired | FRead2 | FMunmap | FReverse, '0, '0, 8'd9, '0);
    send_req(ReqClassify, FPaired | FProper, MitoReset, MitoReset, 8'd60, '0);
    send_req(ReqClassify, '0, MitoReset, '0, 8'd0, '0);
    send_req(ReqClassify, FPaired | FRead2, RefNone, RefNone, 8'd30, '0);
    send_req(ReqClassify, FPaired | FRead1 | FReverse, RefMax, RefMax, 8'd255, '0);
    send_req(ReqReadback, '0, '0, '0, '0, SelWidth'(CMito));
    send_req(ReqReadback, '0, '0, '0, '0, SelWidth'(CUsable));
    send_req(ReqReadback, '0, '0, '0, '0, SelWidth'(CRead1));
    send_req(ReqReadback, '0, '0, '0, '0, SelWidth'(CRead2));
    send_req(ReqReadback, '0, '0, '0, '0, SelWidth'(CDiffchr));
    settle();
    write_reg(CfgIdxThreshold, 32'd256);
    write_reg(CfgIdxMitoId, RefMax);
    send_req(ReqClassify, '0, RefMax, '0, 8'd255, '0);
    send_req(ReqReadback, '0, '0, '0, '0, SelWidth'(CQual));
    send_req(ReqReadback, '0, '0, '0, '0, SelWidth'(CMito));

    for (int p = 0; p < NumPhases; p++) begin
      case (p)
        0: begin thr = 9'd0;   mito = MitoReset; end
        1: begin thr = 9'd255; mito = RefMax;    end
        2: begin thr = 9'd256; mito = 32'd3;     end
        3: begin thr = 9'd10;  mito = 32'd0;     end
        4: begin
          thr  = ThrWidth'($urandom_range(0, 256));
          mito = $urandom_range(0, 5);
        end
        5: begin thr = 9'd1;   mito = RefNone;   end
        6: begin thr = 9'd128; mito = $urandom;  end
        default: begin thr = ThrWidth'($urandom_range(0, 40)); mito = 32'd1; end
      endcase
      settle();
      write_reg(CfgIdxThreshold, CfgWidth'(thr));
      write_reg(CfgIdxMitoId, mito);
      repeat (ItemsPerPhase) begin
        rt = ($urandom_range(0, 3) == 0) ? ReqReadback : ReqClassify;
        if ($urandom_range(0, 3) == 0) begin
          fl = FlagWidth'($urandom);
        end else begin
          fl = '0;
          if ($urandom_range(0, 3) != 0) fl |= FPaired;
          if ($urandom_range(0, 1) != 0) fl |= FProper;
          if ($urandom_range(0, 3) == 0) fl |= FMunmap;
          if ($urandom_range(0, 1) != 0) fl |= FReverse;
          if ($urandom_range(0, 1) != 0) fl |= FRead1;
          if ($urandom_range(0, 1) != 0) fl |= FRead2;
          if ($urandom_range(0, 7) == 0) begin
            case ($urandom_range(0, 3))
              0:       fl |= FUnmap;
              1:       fl |= FSecond;
              2:       fl |= FQcfail;
              default: fl |= FSuppl;
            endcase
          end
        end
        case ($urandom_range(0, 4))
          0:       tid = mito;
          1:       tid = RefNone;
          2:       tid = $urandom;
          default: tid = $urandom_range(0, 3);
        endcase
        case ($urandom_range(0, 3))
          0:       mtid = tid;
          1:       mtid = $urandom;
          2:       mtid = RefNone;
          default: mtid = $urandom_range(0, 3);
        endcase
        if ($urandom_range(0, 1) != 0) begin
          mapq = MapqWidth'($urandom_range(0, 255));
        end else begin
          lo = (int'(thr) > 2) ? int'(thr) - 2 : 0;
          hi = (int'(thr) + 2 > 255) ? 255 : int'(thr) + 2;
          if (lo > 255) lo = 255;
          mapq = MapqWidth'($urandom_range(hi, lo));
        end
        send_req(rt, fl, tid, mtid, mapq, SelWidth'($urandom_range(0, 15)));
      end
    end

    settle();
    repeat (4) @(negedge clk_i);
    if (fail_count == 0) begin
      $display("PASS");
    end else begin
      $display("FAIL");
    end
    $finish;
  end

endmodule

>>> sim.f
design/arfs_pkg.sv
design/arfs_req_if.sv
design/arfs_res_if.sv
design/arfs_classify.sv
design/arfs_counters.sv
design/aligned_read_filter_stats.sv
tb/sv/arfs_stats_checker.sv
tb/sv/tb_aligned_read_filter_stats.sv
